// ===== hw/rtl/sea_pkg.sv =====
// Shared types and constants of the stripe error accumulator.
// Request structs, register indexes and the saturating sum helper.
// No dependencies.
`default_nettype none

package sea_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 44;
    localparam int STRIPE_W  = 56;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Multiplier operand split for the final scaling
    localparam int SPLIT_W = SUM_W / 2;

    // Result queue depth
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_SAMPLES = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] reference_sample;
        logic [SAMPLE_W-1:0] test_sample;
    } in_t;

    typedef struct packed {
        logic [STRIPE_W-1:0] stripe_error;
        logic [SUM_W-1:0]    max_row_error;
        logic [SUM_W-1:0]    max_column_error;
    } out_t;

    // Add two sums, clip at all ones
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sea_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
`default_nettype none

module sea_ram #(
    parameter int DATA_W = 44,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stripe_error_accumulator.sv =====
// Stripe error accumulator: row and column squared-error sums over a frame.
// Throughput: one pixel request per cycle while under RES_DEPTH results are owed;
// the column memory read-modify-write is forwarded from the two previous writes,
// so no interlock stalls occur. Frame results pass stages 3 to 5 into the queue.
// Reset: positions, sums, maxima and queue clear; column memory is not cleared
// (row 0 of every frame writes it before it is read).
`default_nettype none

module stripe_error_accumulator #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_write_en,
    input  wire logic [sea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sea_pkg::DIM_W-1:0]    cfg_data,
    // pixel requests
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire sea_pkg::in_t                 in_data,
    // result requests
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output sea_pkg::out_t                     out_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int DB    = (WB > HB) ? WB : HB;
    localparam int PW    = sea_pkg::SUM_W + DB;
    localparam int LO_W  = sea_pkg::SPLIT_W;
    localparam int HI_W  = sea_pkg::SUM_W - sea_pkg::SPLIT_W;
    localparam int EXT_W = PW + sea_pkg::STRIPE_W;
    localparam int SUM_W = sea_pkg::SUM_W;
    localparam int RES_CNT_W = sea_pkg::RES_PTR_W + 1;

    typedef struct packed {
        logic [CB-1:0] col;
        logic          first_row;
        logic          last_row;
        logic          row_end;
    } ctrl_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WB-1:0] width_reg;
    logic [HB-1:0] height_reg;
    logic          signed_reg;

    // Store sizes already clamped to 1..max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WB'(1);
            height_reg <= HB'(1);
            signed_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                sea_pkg::CFG_FRAME_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_reg <= WB'(1);
                    else if (32'(cfg_data) > MAX_WIDTH)
                        width_reg <= WB'(MAX_WIDTH);
                    else
                        width_reg <= WB'(cfg_data);
                end
                sea_pkg::CFG_FRAME_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_reg <= HB'(1);
                    else if (32'(cfg_data) > MAX_HEIGHT)
                        height_reg <= HB'(MAX_HEIGHT);
                    else
                        height_reg <= HB'(cfg_data);
                end
                sea_pkg::CFG_SIGNED_SAMPLES:
                begin
                    signed_reg <= cfg_data[0];
                end
                default:
                begin
                    signed_reg <= signed_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position tracking, sample difference
    // ------------------------------------------------------------------
    logic [CB-1:0]      col_reg, col_next;
    logic [RB-1:0]      row_reg, row_next;
    logic               accept;
    logic               frame_last;
    ctrl_t              s0_ctrl;
    logic [SB-1:0]      ref_raw, tst_raw;
    logic signed [SB:0] ref_sx, tst_sx;
    logic signed [SB+1:0] diff;
    logic [SB-1:0]      mag;
    logic [RES_CNT_W-1:0] pend_reg;

    assign in_ready = (pend_reg < RES_CNT_W'(sea_pkg::RES_DEPTH));
    assign accept   = in_valid && in_ready;

    assign s0_ctrl.col       = col_reg;
    assign s0_ctrl.first_row = (row_reg == '0);
    assign s0_ctrl.row_end   = ((WB'(col_reg) + WB'(1)) == width_reg);
    assign s0_ctrl.last_row  = ((HB'(row_reg) + HB'(1)) == height_reg);
    assign frame_last        = s0_ctrl.row_end && s0_ctrl.last_row;

    assign ref_raw = in_data.reference_sample[SB-1:0];
    assign tst_raw = in_data.test_sample[SB-1:0];
    assign ref_sx  = $signed({signed_reg & ref_raw[SB-1], ref_raw});
    assign tst_sx  = $signed({signed_reg & tst_raw[SB-1], tst_raw});
    assign diff    = (SB+2)'(ref_sx) - (SB+2)'(tst_sx);
    assign mag     = diff[SB+1] ? SB'(-diff) : SB'(diff);

    // Advance raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (s0_ctrl.row_end)
            begin
                col_next = '0;
                row_next = s0_ctrl.last_row ? '0 : row_reg + RB'(1);
            end
            else
            begin
                col_next = col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Column memory
    // ------------------------------------------------------------------
    logic             wr_en;
    logic [CB-1:0]    wr_addr;
    logic [SUM_W-1:0] wr_data;
    logic [SUM_W-1:0] ram_q;

    sea_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_column_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (col_reg),
        .rd_data (ram_q)
    );

    // ------------------------------------------------------------------
    // Stage 1: square
    // ------------------------------------------------------------------
    logic          s1_valid;
    ctrl_t         s1_ctrl;
    logic [SB-1:0] s1_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid <= 1'b0;
        else
            s1_valid <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_ctrl <= s0_ctrl;
        s1_mag  <= mag;
    end

    // ------------------------------------------------------------------
    // Stage 2: column read-modify-write, row sum, maxima
    // ------------------------------------------------------------------
    logic             s2_valid;
    ctrl_t            s2_ctrl;
    logic [2*SB-1:0]  s2_sq;
    logic [SUM_W-1:0] s2_mem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid <= 1'b0;
        else
            s2_valid <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        s2_ctrl <= s1_ctrl;
        s2_sq   <= s1_mag * s1_mag;
        s2_mem  <= ram_q;
    end

    // Recent writes the memory read did not see yet
    logic             wr1_valid, wr2_valid;
    logic [CB-1:0]    wr1_addr, wr2_addr;
    logic [SUM_W-1:0] wr1_data, wr2_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr1_valid <= 1'b0;
            wr2_valid <= 1'b0;
        end
        else
        begin
            wr1_valid <= wr_en;
            wr2_valid <= wr1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wr1_addr <= wr_addr;
        wr1_data <= wr_data;
        wr2_addr <= wr1_addr;
        wr2_data <= wr1_data;
    end

    logic [SUM_W-1:0] row_sum_reg, row_max_reg, col_max_reg;
    logic [SUM_W-1:0] sq_ext, col_old, csum;
    logic [SUM_W-1:0] row_sum_new, row_max_new, col_max_new;
    logic             frame_end;

    always_comb
    begin
        sq_ext = SUM_W'(s2_sq);
        // Forward the newest pending write to this column
        if (wr1_valid && (wr1_addr == s2_ctrl.col))
            col_old = wr1_data;
        else if (wr2_valid && (wr2_addr == s2_ctrl.col))
            col_old = wr2_data;
        else
            col_old = s2_mem;
        csum        = s2_ctrl.first_row ? sq_ext : sea_pkg::sat_add(col_old, sq_ext);
        row_sum_new = sea_pkg::sat_add(row_sum_reg, sq_ext);
        row_max_new = (s2_ctrl.row_end && (row_sum_new > row_max_reg)) ?
                      row_sum_new : row_max_reg;
        col_max_new = (s2_ctrl.last_row && (csum > col_max_reg)) ? csum : col_max_reg;
        frame_end   = s2_valid && s2_ctrl.row_end && s2_ctrl.last_row;
    end

    assign wr_en   = s2_valid;
    assign wr_addr = s2_ctrl.col;
    assign wr_data = csum;

    // Update running sums; clear the row sum at row end, the maxima at frame end, all on reconfiguration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg <= '0;
            row_max_reg <= '0;
            col_max_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            row_sum_reg <= '0;
            row_max_reg <= '0;
            col_max_reg <= '0;
        end
        else if (s2_valid)
        begin
            row_sum_reg <= s2_ctrl.row_end ? '0 : row_sum_new;
            row_max_reg <= frame_end ? '0 : row_max_new;
            col_max_reg <= frame_end ? '0 : col_max_new;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: capture maxima; stage 4: partial products
    // ------------------------------------------------------------------
    logic             s3_valid, s4_valid, s5_valid;
    logic [SUM_W-1:0] s3_row_max, s3_col_max;
    logic [SUM_W-1:0] s4_row_max, s4_col_max;
    logic [SUM_W-1:0] s5_row_max, s5_col_max;
    logic [HB+LO_W-1:0] s4_rp_lo;
    logic [HB+HI_W-1:0] s4_rp_hi;
    logic [WB+LO_W-1:0] s4_cp_lo;
    logic [WB+HI_W-1:0] s4_cp_hi;
    logic [PW-1:0]      s5_a, s5_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid <= 1'b0;
            s4_valid <= 1'b0;
            s5_valid <= 1'b0;
        end
        else
        begin
            s3_valid <= frame_end;
            s4_valid <= s3_valid;
            s5_valid <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_row_max <= row_max_new;
        s3_col_max <= col_max_new;
        // split products into two narrow multiplies per side
        s4_rp_lo   <= height_reg * s3_row_max[LO_W-1:0];
        s4_rp_hi   <= height_reg * s3_row_max[SUM_W-1:LO_W];
        s4_cp_lo   <= width_reg * s3_col_max[LO_W-1:0];
        s4_cp_hi   <= width_reg * s3_col_max[SUM_W-1:LO_W];
        s4_row_max <= s3_row_max;
        s4_col_max <= s3_col_max;
        // stage 5: recombine
        s5_a       <= PW'(s4_rp_lo) + (PW'(s4_rp_hi) << LO_W);
        s5_b       <= PW'(s4_cp_lo) + (PW'(s4_cp_hi) << LO_W);
        s5_row_max <= s4_row_max;
        s5_col_max <= s4_col_max;
    end

    // Absolute difference, clipped to the output width
    logic [PW-1:0]    s5_diff;
    logic [EXT_W-1:0] s5_ext;
    sea_pkg::out_t    res;

    always_comb
    begin
        s5_diff = (s5_a >= s5_b) ? (s5_a - s5_b) : (s5_b - s5_a);
        s5_ext  = EXT_W'(s5_diff);
        res.stripe_error     = ((s5_ext >> sea_pkg::STRIPE_W) != '0) ?
                               {sea_pkg::STRIPE_W{1'b1}} :
                               s5_ext[sea_pkg::STRIPE_W-1:0];
        res.max_row_error    = s5_row_max;
        res.max_column_error = s5_col_max;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    sea_pkg::out_t                 fifo_mem [sea_pkg::RES_DEPTH];
    logic [sea_pkg::RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0]          fill_reg;
    logic                          pop;

    assign out_valid = (fill_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (s5_valid)
            fifo_mem[wr_ptr_reg] <= res;
    end

    // Hold queue pointers and count of results owed to the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            if (s5_valid)
                wr_ptr_reg <= wr_ptr_reg + sea_pkg::RES_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + sea_pkg::RES_PTR_W'(1);
            fill_reg <= fill_reg + RES_CNT_W'(s5_valid) - RES_CNT_W'(pop);
            pend_reg <= pend_reg + RES_CNT_W'(accept && frame_last) - RES_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire
